// ===== rtl/core/hawkeye_replacement_engine_top_macros.svh =====
// assertion macros used by the engine checker
`ifndef HAWKEYE_REPLACEMENT_ENGINE_TOP_MACROS_SVH
`define HAWKEYE_REPLACEMENT_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define HRE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/hre_pkg.sv =====
`default_nettype none
package hre_pkg;

   // fixed field widths
   localparam int ADDR_W     = 48;
   localparam int PC_SHIFT   = 3;
   localparam int CLOCK_W    = 32;
   localparam int RRIP_W     = 3;
   localparam int PRED_W     = 3;
   localparam int WAY_FIELD_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;
   localparam int SET_KEY_W  = 7;

   localparam logic [RRIP_W-1:0] RRIP_MAX = 3'd7;
   localparam logic [PRED_W-1:0] PRED_MAX = 3'd7;

   // default sizing
   localparam int DEF_WAYS              = 8;
   localparam int DEF_NUM_SETS          = 64;
   localparam int DEF_HISTORY_FACTOR    = 8;
   localparam int DEF_PREDICTOR_ENTRIES = 8192;

   // request codes
   localparam logic [1:0] OP_TOUCH  = 2'd0;
   localparam logic [1:0] OP_FILL   = 2'd1;
   localparam logic [1:0] OP_INVAL  = 2'd2;
   localparam logic [1:0] OP_VICTIM = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOPC_RRIP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRIENDLY_TH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERSE_TH   = 3'd4;

   // register reset values
   localparam logic [3:0] RST_OFFSET_BITS = 4'd6;
   localparam logic [2:0] RST_INDEX_BITS  = 3'd6;
   localparam logic [2:0] RST_NOPC_RRIP   = 3'd6;
   localparam logic [2:0] RST_FRIENDLY_TH = 3'd3;
   localparam logic [2:0] RST_AVERSE_TH   = 3'd4;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [ADDR_W-1:0]      address;
      logic [ADDR_W-1:0]      pc;
      logic                   pc_valid;
      logic [WAY_FIELD_W-1:0] way;
   } hre_req_beat_type;

   typedef struct packed {
      logic [WAY_FIELD_W-1:0] victim_way;
      logic                   victim_was_invalid;
      logic                   friendly;
      logic                   optgen_hit;
      logic                   trained;
   } hre_rsp_beat_type;

   typedef struct packed {
      logic done;
      logic found;
      logic hit;
   } og_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_LOAD, ST_ROW, ST_VSCAN, ST_OG,
      ST_PRD_RD, ST_PRD_WR, ST_FR_RD, ST_FR_USE, ST_APPLY, ST_OUT
   } hre_state_type;

   typedef enum logic [2:0] {
      OG_IDLE, OG_WRITE, OG_SCAN, OG_INC, OG_DONE
   } og_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/hre_ram.sv =====
`default_nettype none
module hre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hre_modred.sv =====
`default_nettype none
module hre_modred #(
   parameter int MOD   = hre_pkg::DEF_PREDICTOR_ENTRIES,
   parameter int VAL_W = hre_pkg::ADDR_W - hre_pkg::PC_SHIFT,
   localparam int RES_W = $clog2(MOD)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] value,
   output logic             done,
   output logic [RES_W-1:0] result
);

   logic [RES_W-1:0] rem_ff, rem_in;
   logic             done_ff, done_in;

   // power-of-two modulus: the remainder is the low bits, ready next cycle
   always_comb begin
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = value[RES_W-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hre_optgen.sv =====
`default_nettype none
module hre_optgen #(
   parameter int WAYS              = hre_pkg::DEF_WAYS,
   parameter int NUM_SETS          = hre_pkg::DEF_NUM_SETS,
   parameter int HISTORY_FACTOR    = hre_pkg::DEF_HISTORY_FACTOR,
   parameter int PREDICTOR_ENTRIES = hre_pkg::DEF_PREDICTOR_ENTRIES,
   localparam int CAP    = HISTORY_FACTOR * WAYS,
   localparam int SLOT_W = $clog2(CAP),
   localparam int FILL_W = $clog2(CAP + 1),
   localparam int HDEPTH = NUM_SETS * CAP,
   localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1,
   localparam int HASH_W = $clog2(PREDICTOR_ENTRIES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [HAW-1:0]            set_base,
   input  logic [SLOT_W-1:0]         cur_head,
   input  logic [FILL_W-1:0]         cur_fill,
   input  logic [hre_pkg::ADDR_W-1:0] line,
   input  logic [HASH_W-1:0]         hash,
   output hre_pkg::og_status_type    status,
   output logic [SLOT_W-1:0]         new_head,
   output logic [FILL_W-1:0]         new_fill,
   output logic [HASH_W-1:0]         prior_hash
);

   localparam int OCC_W   = $clog2(WAYS + 1);
   localparam int ENTRY_W = hre_pkg::ADDR_W + HASH_W + OCC_W;
   localparam logic [SLOT_W:0] CAP_C = (SLOT_W + 1)'(CAP);

   hre_pkg::og_state_type st_ff, st_in;

   logic [HAW-1:0]             base_ff, base_in;
   logic [SLOT_W-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]          n_ff, n_in;
   logic [hre_pkg::ADDR_W-1:0] line_ff, line_in;
   logic [HASH_W-1:0]          hash_ff, hash_in;
   logic [SLOT_W-1:0]          rd_pos_ff, rd_pos_in;
   logic                       rd_more_ff, rd_more_in;
   logic                       chk_valid_ff, chk_valid_in;
   logic [SLOT_W-1:0]          chk_pos_ff, chk_pos_in;
   logic [SLOT_W-1:0]          end_pos_ff, end_pos_in;
   logic                       allok_ff, allok_in;
   logic                       found_ff, found_in;
   logic                       hit_ff, hit_in;
   logic [HASH_W-1:0]          phash_ff, phash_in;

   logic               wr_en;
   logic [HAW-1:0]     wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [HAW-1:0]     rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic [hre_pkg::ADDR_W-1:0] ent_line;
   logic [HASH_W-1:0]          ent_hash;
   logic [OCC_W-1:0]           ent_occ;
   logic [SLOT_W-1:0]          last_old;

   // history position to memory address, wrapping inside the set's ring
   function automatic logic [HAW-1:0] pos_addr(input logic [HAW-1:0] base,
                                               input logic [SLOT_W-1:0] head,
                                               input logic [SLOT_W-1:0] pos);
      logic [SLOT_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= CAP_C) begin
         sum = sum - CAP_C;
      end
      return base + HAW'(sum);
   endfunction

   hre_ram #(.WIDTH(ENTRY_W), .DEPTH(HDEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_line = rd_data[ENTRY_W-1 -: hre_pkg::ADDR_W];
   assign ent_hash = rd_data[OCC_W +: HASH_W];
   assign ent_occ  = rd_data[OCC_W-1:0];
   assign last_old = SLOT_W'(n_ff - FILL_W'(2));
   assign rd_addr  = pos_addr(base_ff, head_ff, rd_pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= hre_pkg::OG_IDLE;
      end else begin
         st_ff <= st_in;
      end
      base_ff      <= base_in;
      head_ff      <= head_in;
      n_ff         <= n_in;
      line_ff      <= line_in;
      hash_ff      <= hash_in;
      rd_pos_ff    <= rd_pos_in;
      rd_more_ff   <= rd_more_in;
      chk_valid_ff <= chk_valid_in;
      chk_pos_ff   <= chk_pos_in;
      end_pos_ff   <= end_pos_in;
      allok_ff     <= allok_in;
      found_ff     <= found_in;
      hit_ff       <= hit_in;
      phash_ff     <= phash_in;
   end

   // sequencer: append, backward match scan, occupancy bump
   always_comb begin
      st_in        = st_ff;
      base_in      = base_ff;
      head_in      = head_ff;
      n_in         = n_ff;
      line_in      = line_ff;
      hash_in      = hash_ff;
      rd_pos_in    = rd_pos_ff;
      rd_more_in   = rd_more_ff;
      chk_valid_in = 1'b0;
      chk_pos_in   = chk_pos_ff;
      end_pos_in   = end_pos_ff;
      allok_in     = allok_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      phash_in     = phash_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_addr(base_ff, head_ff, SLOT_W'(n_ff - FILL_W'(1)));
      wr_data      = {line_ff, hash_ff, OCC_W'(1)};
      status       = '0;
      unique case (st_ff)
         hre_pkg::OG_IDLE: begin
            if (start) begin
               base_in  = set_base;
               line_in  = line;
               hash_in  = hash;
               found_in = 1'b0;
               hit_in   = 1'b0;
               // full history drops its oldest entry
               if (cur_fill >= FILL_W'(CAP)) begin
                  head_in = (cur_head == SLOT_W'(CAP - 1)) ? '0 : cur_head + 1'b1;
                  n_in    = FILL_W'(CAP);
               end else begin
                  head_in = cur_head;
                  n_in    = cur_fill + 1'b1;
               end
               st_in = hre_pkg::OG_WRITE;
            end
         end
         hre_pkg::OG_WRITE: begin
            wr_en = 1'b1;
            if (n_ff < FILL_W'(2)) begin
               st_in = hre_pkg::OG_DONE;
            end else begin
               rd_pos_in  = last_old;
               rd_more_in = 1'b1;
               allok_in   = 1'b1;
               st_in      = hre_pkg::OG_SCAN;
            end
         end
         hre_pkg::OG_SCAN: begin
            if (rd_more_ff) begin
               chk_valid_in = 1'b1;
               chk_pos_in   = rd_pos_ff;
               rd_pos_in    = rd_pos_ff - 1'b1;
               rd_more_in   = (rd_pos_ff != '0);
            end
            if (chk_valid_ff) begin
               if (ent_line == line_ff) begin
                  found_in = 1'b1;
                  hit_in   = allok_ff;
                  phash_in = ent_hash;
                  if (allok_ff && (chk_pos_ff != last_old)) begin
                     rd_pos_in    = chk_pos_ff + 1'b1;
                     rd_more_in   = 1'b1;
                     end_pos_in   = last_old;
                     chk_valid_in = 1'b0;
                     st_in        = hre_pkg::OG_INC;
                  end else begin
                     st_in = hre_pkg::OG_DONE;
                  end
               end else begin
                  allok_in = allok_ff && (ent_occ < OCC_W'(WAYS));
                  if (chk_pos_ff == '0) begin
                     st_in = hre_pkg::OG_DONE;
                  end
               end
            end
         end
         hre_pkg::OG_INC: begin
            if (rd_more_ff) begin
               chk_valid_in = 1'b1;
               chk_pos_in   = rd_pos_ff;
               rd_pos_in    = rd_pos_ff + 1'b1;
               rd_more_in   = (rd_pos_ff != end_pos_ff);
            end
            // write back the entry read last cycle with one more occupant
            if (chk_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_addr(base_ff, head_ff, chk_pos_ff);
               wr_data = {ent_line, ent_hash, ent_occ + 1'b1};
               if (chk_pos_ff == end_pos_ff) begin
                  st_in = hre_pkg::OG_DONE;
               end
            end
         end
         hre_pkg::OG_DONE: begin
            status.done  = 1'b1;
            status.found = found_ff;
            status.hit   = hit_ff;
            st_in        = hre_pkg::OG_IDLE;
         end
         default: begin
            st_in = hre_pkg::OG_IDLE;
         end
      endcase
   end

   assign new_head   = head_ff;
   assign new_fill   = n_ff;
   assign prior_hash = phash_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hawkeye_replacement_engine_top.sv =====
// Hawkeye replacement engine for a set-associative cache.
// Events arrive on the req_ channel (valid/ready): hit touch, fill,
// invalidate or victim query. Each accepted beat gives exactly one rsp_
// beat with the victim way and the predictor / history verdicts.
// Registers are written on the csr_ channel, which is always ready; write
// them only while no event is in flight.
// One event is handled at a time; req_ready is low until its result is
// registered and rises together with rsp_valid. A victim query loads the
// set row and then compares one way per cycle. A touch or fill with a PC
// and an in-range way runs the PC hash slice, row load, history append, a
// backward scan of the history to the earlier reference, an occupancy raise
// on the entries after it, and the predictor / way update. After reset the
// block runs a clearing pass over the predictor and per-set state, with
// req_ready low. A stalled result is held in the output register; the next
// event is still accepted and runs up to its own result.
`default_nettype none
module hawkeye_replacement_engine_top #(
   parameter int WAYS              = hre_pkg::DEF_WAYS,
   parameter int NUM_SETS          = hre_pkg::DEF_NUM_SETS,
   parameter int HISTORY_FACTOR    = hre_pkg::DEF_HISTORY_FACTOR,
   parameter int PREDICTOR_ENTRIES = hre_pkg::DEF_PREDICTOR_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hre_pkg::hre_req_beat_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output hre_pkg::hre_rsp_beat_type          rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hre_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hre_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int WAY_W   = $clog2(WAYS);
   localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int CAP     = HISTORY_FACTOR * WAYS;
   localparam int SLOT_W  = $clog2(CAP);
   localparam int FILL_W  = $clog2(CAP + 1);
   localparam int HDEPTH  = NUM_SETS * CAP;
   localparam int HAW     = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int HASH_W  = $clog2(PREDICTOR_ENTRIES);
   localparam int CW      = hre_pkg::CLOCK_W;
   localparam int RW      = hre_pkg::RRIP_W;
   localparam int PW      = hre_pkg::PRED_W;
   localparam int VAL_LO  = WAYS * CW;
   localparam int RR_LO   = VAL_LO + WAYS;
   localparam int FI_LO   = RR_LO + WAYS * RW;
   localparam int HD_LO   = FI_LO + FILL_W;
   localparam int ROW_W   = HD_LO + SLOT_W;
   localparam int CLR_N   = (PREDICTOR_ENTRIES > NUM_SETS) ? PREDICTOR_ENTRIES : NUM_SETS;
   localparam int CLR_W   = $clog2(CLR_N);
   localparam int KEYS    = 1 << hre_pkg::SET_KEY_W;
   localparam int HV_W    = hre_pkg::ADDR_W - hre_pkg::PC_SHIFT;

   hre_pkg::hre_state_type st_ff, st_in;

   // configuration
   logic [3:0]    offset_ff;
   logic [2:0]    index_ff, nopc_ff, fth_ff, ath_ff;

   // current event
   logic [1:0]                 op_ff, op_in;
   logic                       pcv_ff, pcv_in;
   logic [hre_pkg::WAY_FIELD_W-1:0] way_ff, way_in;
   logic [hre_pkg::ADDR_W-1:0] line_ff, line_in;
   logic [SET_W-1:0]           set_ff, set_in;
   logic [CW-1:0]              clock_ff, clock_in;
   logic [CLR_W-1:0]           clr_ff, clr_in;

   // loaded set row
   logic [WAYS-1:0][RW-1:0] rrip_ff, rrip_in;
   logic [WAYS-1:0]         valid_ff, valid_in;
   logic [WAYS-1:0][CW-1:0] lt_ff, lt_in;
   logic [SLOT_W-1:0]       rhead_ff, rhead_in;
   logic [FILL_W-1:0]       rfill_ff, rfill_in;

   // victim scan
   logic [WAY_W-1:0] vw_ff, vw_in;
   logic             inv_found_ff, inv_found_in;
   logic [WAY_W-1:0] inv_way_ff, inv_way_in;
   logic [RW-1:0]    max_r_ff, max_r_in;
   logic [WAY_W-1:0] max_w_ff, max_w_in;
   logic [CW-1:0]    min_lt_ff, min_lt_in;
   logic [WAY_W-1:0] min_w_ff, min_w_in;

   // result
   logic [hre_pkg::WAY_FIELD_W-1:0] res_vway_ff, res_vway_in;
   logic res_vinv_ff, res_vinv_in, res_fr_ff, res_fr_in;
   logic res_hit_ff, res_hit_in, res_tr_ff, res_tr_in;
   logic rsp_valid_ff, rsp_valid_in;
   hre_pkg::hre_rsp_beat_type rsp_data_ff, rsp_data_in;

   // memories and units
   logic             set_we;
   logic [SET_W-1:0] set_waddr;
   logic [ROW_W-1:0] set_wdata, set_rdata, row_new;
   logic             pred_we;
   logic [HASH_W-1:0] pred_waddr, pred_raddr;
   logic [PW-1:0]    pred_wdata, pred_rdata;
   logic             hash_start, hash_done;
   logic [HASH_W-1:0] hash_res, prior_hash;
   logic             og_start;
   hre_pkg::og_status_type og_status;
   logic [SLOT_W-1:0] og_head;
   logic [FILL_W-1:0] og_fill;
   logic [HAW-1:0]    set_base;

   logic                      accept;
   logic                      way_ok;
   logic [hre_pkg::ADDR_W-1:0] acc_line;
   logic [hre_pkg::SET_KEY_W-1:0] acc_key;
   logic [SET_W-1:0]          set_map [KEYS];
   logic [WAYS-1:0][RW-1:0]   n_rrip;
   logic [WAYS-1:0]           n_valid;
   logic [WAYS-1:0][CW-1:0]   n_lt;
   logic [SLOT_W-1:0]         n_head;
   logic [FILL_W-1:0]         n_fill;
   logic                      og_path;

   // set number of each masked line key, wrapped into range
   for (genvar g = 0; g < KEYS; g++) begin : g_set_map
      assign set_map[g] = SET_W'(g % NUM_SETS);
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (st_ff == hre_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign acc_line  = req_data.address >> offset_ff;
   assign acc_key   = hre_pkg::SET_KEY_W'(acc_line) &
                      hre_pkg::SET_KEY_W'((8'd1 << index_ff) - 8'd1);
   assign way_ok    = (int'(way_ff) < WAYS);
   assign og_path   = pcv_ff && ((op_ff == hre_pkg::OP_TOUCH) || (op_ff == hre_pkg::OP_FILL));
   assign set_base  = HAW'(int'(set_ff) * CAP);
   assign hash_start = accept && req_data.pc_valid && (int'(req_data.way) < WAYS) &&
                       ((req_data.req_type == hre_pkg::OP_TOUCH) ||
                        (req_data.req_type == hre_pkg::OP_FILL));

   hre_modred #(.MOD(PREDICTOR_ENTRIES), .VAL_W(HV_W)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .value  (req_data.pc[hre_pkg::ADDR_W-1:hre_pkg::PC_SHIFT]),
      .done   (hash_done),
      .result (hash_res)
   );

   hre_optgen #(
      .WAYS(WAYS), .NUM_SETS(NUM_SETS), .HISTORY_FACTOR(HISTORY_FACTOR),
      .PREDICTOR_ENTRIES(PREDICTOR_ENTRIES)
   ) u_optgen (
      .clock      (clock),
      .reset      (reset),
      .start      (og_start),
      .set_base   (set_base),
      .cur_head   (rhead_ff),
      .cur_fill   (rfill_ff),
      .line       (line_ff),
      .hash       (hash_res),
      .status     (og_status),
      .new_head   (og_head),
      .new_fill   (og_fill),
      .prior_hash (prior_hash)
   );

   hre_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_set_ram (
      .clock   (clock),
      .wr_en   (set_we),
      .wr_addr (set_waddr),
      .wr_data (set_wdata),
      .rd_addr (set_ff),
      .rd_data (set_rdata)
   );

   hre_ram #(.WIDTH(PW), .DEPTH(PREDICTOR_ENTRIES)) u_pred_ram (
      .clock   (clock),
      .wr_en   (pred_we),
      .wr_addr (pred_waddr),
      .wr_data (pred_wdata),
      .rd_addr (pred_raddr),
      .rd_data (pred_rdata)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= hre_pkg::RST_OFFSET_BITS;
         index_ff  <= hre_pkg::RST_INDEX_BITS;
         nopc_ff   <= hre_pkg::RST_NOPC_RRIP;
         fth_ff    <= hre_pkg::RST_FRIENDLY_TH;
         ath_ff    <= hre_pkg::RST_AVERSE_TH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hre_pkg::CSR_OFFSET_BITS: offset_ff <= csr_wdata;
            hre_pkg::CSR_INDEX_BITS:  index_ff  <= csr_wdata[2:0];
            hre_pkg::CSR_NOPC_RRIP:   nopc_ff   <= csr_wdata[2:0];
            hre_pkg::CSR_FRIENDLY_TH: fth_ff    <= csr_wdata[2:0];
            hre_pkg::CSR_AVERSE_TH:   ath_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // updated row for touch, fill and invalidate
   always_comb begin
      n_rrip  = rrip_ff;
      n_valid = valid_ff;
      n_lt    = lt_ff;
      n_head  = og_path ? og_head : rhead_ff;
      n_fill  = og_path ? og_fill : rfill_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (int'(way_ff) == w) begin
            if (op_ff == hre_pkg::OP_INVAL) begin
               n_valid[w] = 1'b0;
               n_lt[w]    = '0;
            end else begin
               n_lt[w] = clock_ff;
               if (op_ff == hre_pkg::OP_FILL) begin
                  n_valid[w] = 1'b1;
               end
               if (pcv_ff) begin
                  n_rrip[w] = res_fr_ff ? '0 : hre_pkg::RRIP_MAX;
               end else if (op_ff == hre_pkg::OP_FILL) begin
                  n_rrip[w] = nopc_ff;
               end
            end
         end else if (pcv_ff && (op_ff == hre_pkg::OP_FILL) && res_fr_ff && valid_ff[w] &&
                      (rrip_ff[w] < hre_pkg::RRIP_MAX)) begin
            n_rrip[w] = rrip_ff[w] + 1'b1;
         end
      end
      row_new = {n_head, n_fill, n_rrip, n_valid, n_lt};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= hre_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      pcv_ff       <= pcv_in;
      way_ff       <= way_in;
      line_ff      <= line_in;
      set_ff       <= set_in;
      rrip_ff      <= rrip_in;
      valid_ff     <= valid_in;
      lt_ff        <= lt_in;
      rhead_ff     <= rhead_in;
      rfill_ff     <= rfill_in;
      vw_ff        <= vw_in;
      inv_found_ff <= inv_found_in;
      inv_way_ff   <= inv_way_in;
      max_r_ff     <= max_r_in;
      max_w_ff     <= max_w_in;
      min_lt_ff    <= min_lt_in;
      min_w_ff     <= min_w_in;
      res_vway_ff  <= res_vway_in;
      res_vinv_ff  <= res_vinv_in;
      res_fr_ff    <= res_fr_in;
      res_hit_ff   <= res_hit_in;
      res_tr_ff    <= res_tr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // event sequencer
   always_comb begin
      st_in        = st_ff;
      clr_in       = clr_ff;
      clock_in     = clock_ff;
      op_in        = op_ff;
      pcv_in       = pcv_ff;
      way_in       = way_ff;
      line_in      = line_ff;
      set_in       = set_ff;
      rrip_in      = rrip_ff;
      valid_in     = valid_ff;
      lt_in        = lt_ff;
      rhead_in     = rhead_ff;
      rfill_in     = rfill_ff;
      vw_in        = vw_ff;
      inv_found_in = inv_found_ff;
      inv_way_in   = inv_way_ff;
      max_r_in     = max_r_ff;
      max_w_in     = max_w_ff;
      min_lt_in    = min_lt_ff;
      min_w_in     = min_w_ff;
      res_vway_in  = res_vway_ff;
      res_vinv_in  = res_vinv_ff;
      res_fr_in    = res_fr_ff;
      res_hit_in   = res_hit_ff;
      res_tr_in    = res_tr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      set_we       = 1'b0;
      set_waddr    = set_ff;
      set_wdata    = row_new;
      pred_we      = 1'b0;
      pred_waddr   = prior_hash;
      pred_wdata   = pred_rdata;
      pred_raddr   = (st_ff == hre_pkg::ST_FR_RD) ? hash_res : prior_hash;
      og_start     = 1'b0;
      unique case (st_ff)
         hre_pkg::ST_CLEAR: begin
            // reset sweep over predictor and set rows
            if (int'(clr_ff) < PREDICTOR_ENTRIES) begin
               pred_we    = 1'b1;
               pred_waddr = HASH_W'(clr_ff);
               pred_wdata = '0;
            end
            if (int'(clr_ff) < NUM_SETS) begin
               set_we    = 1'b1;
               set_waddr = SET_W'(clr_ff);
               set_wdata = {SLOT_W'(0), FILL_W'(0), {WAYS{hre_pkg::RRIP_MAX}},
                            WAYS'(0), (WAYS * CW)'(0)};
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               st_in = hre_pkg::ST_IDLE;
            end
         end
         hre_pkg::ST_IDLE: begin
            if (accept) begin
               op_in       = req_data.req_type;
               pcv_in      = req_data.pc_valid;
               way_in      = req_data.way;
               line_in     = acc_line;
               set_in      = set_map[acc_key];
               clock_in    = clock_ff + 1'b1;
               res_vway_in = '0;
               res_vinv_in = 1'b0;
               res_fr_in   = 1'b0;
               res_hit_in  = 1'b0;
               res_tr_in   = 1'b0;
               st_in       = hash_start ? hre_pkg::ST_HASH : hre_pkg::ST_LOAD;
            end
         end
         hre_pkg::ST_HASH: begin
            if (hash_done) begin
               st_in = hre_pkg::ST_LOAD;
            end
         end
         hre_pkg::ST_LOAD: begin
            st_in = hre_pkg::ST_ROW;
         end
         hre_pkg::ST_ROW: begin
            lt_in        = set_rdata[VAL_LO-1:0];
            valid_in     = set_rdata[RR_LO-1:VAL_LO];
            rrip_in      = set_rdata[FI_LO-1:RR_LO];
            rfill_in     = set_rdata[HD_LO-1:FI_LO];
            rhead_in     = set_rdata[ROW_W-1:HD_LO];
            vw_in        = '0;
            inv_found_in = 1'b0;
            max_r_in     = '0;
            max_w_in     = '0;
            if (op_ff == hre_pkg::OP_VICTIM) begin
               st_in = hre_pkg::ST_VSCAN;
            end else if (!way_ok) begin
               st_in = hre_pkg::ST_OUT;
            end else if (og_path) begin
               st_in = hre_pkg::ST_OG;
            end else begin
               st_in = hre_pkg::ST_APPLY;
            end
         end
         hre_pkg::ST_VSCAN: begin
            // one way per cycle: first invalid, highest rrip, oldest touch
            if (!valid_ff[vw_ff] && !inv_found_ff) begin
               inv_found_in = 1'b1;
               inv_way_in   = vw_ff;
            end
            if (rrip_ff[vw_ff] > max_r_ff) begin
               max_r_in = rrip_ff[vw_ff];
               max_w_in = vw_ff;
            end
            if ((vw_ff == '0) || (lt_ff[vw_ff] < min_lt_ff)) begin
               min_lt_in = lt_ff[vw_ff];
               min_w_in  = vw_ff;
            end
            vw_in = vw_ff + 1'b1;
            if (vw_ff == WAY_W'(WAYS - 1)) begin
               if (inv_found_in) begin
                  res_vway_in = hre_pkg::WAY_FIELD_W'(inv_way_in);
                  res_vinv_in = 1'b1;
               end else if (max_r_in < ath_ff) begin
                  res_vway_in = hre_pkg::WAY_FIELD_W'(min_w_in);
               end else begin
                  res_vway_in = hre_pkg::WAY_FIELD_W'(max_w_in);
               end
               st_in = hre_pkg::ST_OUT;
            end
         end
         hre_pkg::ST_OG: begin
            og_start = 1'b1;
            if (og_status.done) begin
               og_start   = 1'b0;
               res_tr_in  = og_status.found;
               res_hit_in = og_status.found && og_status.hit;
               st_in      = og_status.found ? hre_pkg::ST_PRD_RD : hre_pkg::ST_FR_RD;
            end
         end
         hre_pkg::ST_PRD_RD: begin
            st_in = hre_pkg::ST_PRD_WR;
         end
         hre_pkg::ST_PRD_WR: begin
            // saturating train of the earlier reference's entry
            pred_we = 1'b1;
            if (res_hit_ff) begin
               pred_wdata = (pred_rdata < hre_pkg::PRED_MAX) ? pred_rdata + 1'b1 : pred_rdata;
            end else begin
               pred_wdata = (pred_rdata != '0) ? pred_rdata - 1'b1 : pred_rdata;
            end
            st_in = hre_pkg::ST_FR_RD;
         end
         hre_pkg::ST_FR_RD: begin
            st_in = hre_pkg::ST_FR_USE;
         end
         hre_pkg::ST_FR_USE: begin
            res_fr_in = (pred_rdata >= fth_ff);
            st_in     = hre_pkg::ST_APPLY;
         end
         hre_pkg::ST_APPLY: begin
            set_we = 1'b1;
            st_in  = hre_pkg::ST_OUT;
         end
         hre_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.victim_way         = res_vway_ff;
               rsp_data_in.victim_was_invalid = res_vinv_ff;
               rsp_data_in.friendly           = res_fr_ff;
               rsp_data_in.optgen_hit         = res_hit_ff;
               rsp_data_in.trained            = res_tr_ff;
               st_in                          = hre_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = hre_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hre_checker.sv =====
`default_nettype none
`include "hawkeye_replacement_engine_top_macros.svh"
module hre_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input hre_pkg::hre_rsp_beat_type rsp_data
);

   // stalled result beat holds
   `HRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // one event at a time
   `HRE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "req accepted while an event is in flight")

   // invalid-way victim answers carry no predictor verdicts
   `HRE_ASSERT_NOW(a_victim_clean, clock, reset, rsp_valid && rsp_data.victim_was_invalid, !rsp_data.friendly && !rsp_data.optgen_hit && !rsp_data.trained, "invalid-way victim with predictor flags")

   // a history verdict only comes with training
   `HRE_ASSERT_NOW(a_hit_needs_train, clock, reset, rsp_valid && !rsp_data.trained, !rsp_data.optgen_hit, "optgen hit without training")

endmodule

bind hawkeye_replacement_engine_top hre_checker u_hre_checker (.*);
`default_nettype wire
